FILE: rtl/core/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  // Fixed widths of the offset fields and of the configuration registers.
  localparam int unsigned OffsetBits = 20;
  localparam int unsigned CfgBits    = 21;

  // Request modes; the last code is reserved and always fails.
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_HEAP_LIMIT   = 1'b0;
  localparam logic CFG_INITIAL_SIZE = 1'b1;

  // Largest usable heap size, one past the highest offset.
  localparam logic [CfgBits-1:0] OffsetSpan = CfgBits'(1) << OffsetBits;

  // One table entry: header offset, payload size and free mark.
  typedef struct packed {
    logic [OffsetBits-1:0] start;
    logic [OffsetBits-1:0] bytes;
    logic                  free;
  } ent_t;

endpackage
`default_nettype wire

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: table ring and pass controller.
// Requests (mode, request_size, address) arrive on a valid/ready channel and
// each gives one response (status, payload_offset) on a valid/ready channel.
// The block table lives in a ring of MAX_BLOCKS cells. Every allocate, free
// or initialize request rotates the whole ring once through the controller,
// which rewrites the entries as they pass: it marks, splits, appends or
// merges blocks in address order.
// A free spends longer in the ring than an allocate or initialize, as set by
// the ring length and the controller's short reorder queue; the response is
// valid right after the last ring cycle. Requests that fail before any table
// work (heap not initialized, bad initial size, unknown mode) have their
// response in the cycle after they are taken.
// One request is worked at a time: ready is high only while the block is
// idle and no response is pending. Without stalls the block goes from the
// response state back to idle, where it takes the next request.
// Reset leaves the heap uninitialized, heap_limit at 1048576 and
// initial_size at 4096. The table itself needs no clearing.
// A stalled response is held unchanged until it is taken; the block then
// takes the next request.
// Configuration writes are taken at once and must only occur while idle.
`default_nettype none
module first_fit_heap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                req_valid_i,
  output logic                               req_ready_o,
  input  wire  [1:0]                         mode_i,
  input  wire  [ffha_pkg::OffsetBits-1:0]    request_size_i,
  input  wire  [ffha_pkg::OffsetBits-1:0]    address_i,
  output logic                               rsp_valid_o,
  input  wire                                rsp_ready_i,
  output logic                               status_o,
  output logic [ffha_pkg::OffsetBits-1:0]    payload_offset_o,
  input  wire                                cfg_we_i,
  input  wire                                cfg_index_i,
  input  wire  [ffha_pkg::CfgBits-1:0]       cfg_data_i
);
  import ffha_pkg::*;

  localparam int unsigned TW = $clog2(MAX_BLOCKS + 4);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW = OffsetBits + 2;
  localparam logic [SW-1:0] Hdr = SW'(HEADER_BYTES);
  localparam logic [TW-1:0] LastPop = TW'(MAX_BLOCKS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_RSP} state_e;
  typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_INIT} op_e;

  state_e state_q;
  op_e    op_q;
  logic [TW-1:0] t_q;
  logic [1:0]    lag_q;
  logic [OffsetBits-1:0] size_q, addr_q, pay_q;
  logic found_q, dec_q, just_q, status_q;
  logic [CW-1:0] count_q, cnt_nx_q, cnt_nx_d;
  logic [CfgBits-1:0] heap_used_q, heap_used_nx_q, heap_used_nx_d;
  logic ready_q;
  logic [CfgBits-1:0] heap_limit_q, initial_size_q;
  ent_t [3:0] lq_q, lq_d;
  logic [3:0] lv_q, lv_d;
  logic [2:0] ln_q, ln_d;
  logic found_d, dec_d, just_d;
  logic [OffsetBits-1:0] pay_d;

  // Ring of table cells; the head is cell 0, the tail takes the emitted entry.
  ent_t [MAX_BLOCKS-1:0] cell_q;
  ent_t emit;
  logic shift;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    if (g == MAX_BLOCKS - 1) begin : g_tail
      ffha_cell u_cell (.clk_i(clk_i), .shift_i(shift), .ent_i(emit), .ent_o(cell_q[g]));
    end else begin : g_body
      ffha_cell u_cell (.clk_i(clk_i), .shift_i(shift), .ent_i(cell_q[g+1]),
                        .ent_o(cell_q[g]));
    end
  end

  assign shift = (state_q == ST_RUN);

  // Head entry arithmetic shared by the passes.
  ent_t head;
  logic hv, pop_real, fits, split_ok, grow_ok, addr_hit, emit_now, last;
  logic [OffsetBits-1:0] left;
  logic [SW-1:0] head_pl, grow_sum;
  logic [CfgBits-1:0] cap;

  assign head     = cell_q[0];
  assign pop_real = (t_q <= LastPop);
  assign hv       = pop_real && (t_q < TW'(count_q));
  assign fits     = head.bytes >= size_q;
  assign left     = head.bytes - size_q;
  assign split_ok = ({2'b00, left} >= Hdr + SW'(1)) && (count_q < CW'(MAX_BLOCKS));
  assign head_pl  = {2'b00, head.start} + Hdr;
  assign addr_hit = (head_pl == {2'b00, addr_q});
  assign cap      = (heap_limit_q > OffsetSpan) ? OffsetSpan : heap_limit_q;
  assign grow_sum = {2'b00, size_q} + Hdr + {1'b0, heap_used_q};
  assign grow_ok  = grow_sum < {1'b0, cap};
  assign emit_now = (t_q >= TW'(lag_q));
  assign last     = (t_q == LastPop + TW'(lag_q));

  // Pass step: turn the head entry into appended entries or a merge into
  // the queue's back, and emit the queue's front to the ring's tail.
  always_comb begin
    ent_t ap0, ap1;
    logic av0, av1, mrg;
    logic [1:0] nap;
    logic [OffsetBits-1:0] madd;
    ent_t [3:0] tq;
    logic [3:0] tv;
    logic [2:0] n;

    ap0 = head;
    ap1 = head;
    av0 = hv;
    av1 = 1'b0;
    nap = 2'd0;
    mrg = 1'b0;
    madd = head.bytes + OffsetBits'(HEADER_BYTES);
    found_d = found_q;
    dec_d = dec_q;
    just_d = 1'b0;
    pay_d = pay_q;
    cnt_nx_d = cnt_nx_q;
    heap_used_nx_d = heap_used_nx_q;
    emit = '0;

    if (pop_real) begin
      nap = 2'd1;
      case (op_q)
        OP_ALLOC: begin
          if (!dec_q && hv && head.free && fits) begin
            dec_d = 1'b1;
            found_d = 1'b1;
            pay_d = head_pl[OffsetBits-1:0];
            ap0.free = 1'b0;
            if (split_ok) begin
              ap0.bytes = size_q;
              ap1.start = head_pl[OffsetBits-1:0] + size_q;
              ap1.bytes = left - OffsetBits'(HEADER_BYTES);
              ap1.free = 1'b1;
              av1 = 1'b1;
              nap = 2'd2;
              cnt_nx_d = cnt_nx_q + CW'(1);
            end
          end else if (!dec_q && !hv) begin
            dec_d = 1'b1;
            if (grow_ok) begin
              found_d = 1'b1;
              ap0.start = heap_used_q[OffsetBits-1:0];
              ap0.bytes = size_q;
              ap0.free = 1'b0;
              av0 = 1'b1;
              pay_d = heap_used_q[OffsetBits-1:0] + OffsetBits'(HEADER_BYTES);
              heap_used_nx_d = grow_sum[CfgBits-1:0];
              cnt_nx_d = cnt_nx_q + CW'(1);
            end
          end
        end
        OP_FREE: begin
          if (!dec_q && hv && addr_hit) begin
            dec_d = 1'b1;
            if (!head.free) begin
              found_d = 1'b1;
              just_d = 1'b1;
              ap0.free = 1'b1;
              if (ln_q != 3'd0) begin
                if (lv_q[2'(ln_q - 3'd1)] && lq_q[2'(ln_q - 3'd1)].free) begin
                  mrg = 1'b1;
                end
              end
            end
          end else if (just_q && hv && head.free) begin
            mrg = 1'b1;
          end
          if (mrg) begin
            nap = 2'd0;
            cnt_nx_d = cnt_nx_d - CW'(1);
          end
        end
        default: begin
          // Initialize: the first slot gets the single free block.
          if (t_q == '0) begin
            ap0.start = '0;
            ap0.bytes = initial_size_q[OffsetBits-1:0] - OffsetBits'(HEADER_BYTES);
            ap0.free = 1'b1;
            av0 = 1'b1;
          end else begin
            ap0 = '0;
            av0 = 1'b0;
          end
        end
      endcase
    end

    // Queue update: merge at the back, pop the front, append.
    tq = lq_q;
    tv = lv_q;
    n = ln_q;
    for (int k = 0; k < 4; k++) begin
      if (mrg && (3'(k) + 3'd1 == n)) begin
        tq[k].bytes = tq[k].bytes + madd;
      end
    end
    if (emit_now && n != 3'd0) begin
      emit = tq[0];
      for (int k = 0; k < 3; k++) begin
        tq[k] = tq[k+1];
        tv[k] = tv[k+1];
      end
      n = n - 3'd1;
    end
    for (int k = 0; k < 4; k++) begin
      if (nap != 2'd0 && 3'(k) == n) begin
        tq[k] = ap0;
        tv[k] = av0;
      end
      if (nap == 2'd2 && 3'(k) == n + 3'd1) begin
        tq[k] = ap1;
        tv[k] = av1;
      end
    end
    lq_d = tq;
    lv_d = tv;
    ln_d = n + 3'(nap);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= OffsetSpan;
      initial_size_q <= CfgBits'(4096);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_HEAP_LIMIT) begin
        heap_limit_q <= cfg_data_i;
      end else begin
        initial_size_q <= cfg_data_i;
      end
    end
  end

  // Controller state, heap bookkeeping and the response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= OP_ALLOC;
      t_q <= '0;
      lag_q <= 2'd1;
      found_q <= 1'b0;
      dec_q <= 1'b0;
      just_q <= 1'b0;
      ln_q <= 3'd0;
      lv_q <= '0;
      lq_q <= '0;
      size_q <= '0;
      addr_q <= '0;
      count_q <= '0;
      cnt_nx_q <= '0;
      heap_used_q <= '0;
      heap_used_nx_q <= '0;
      ready_q <= 1'b0;
      status_q <= 1'b1;
      pay_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            t_q <= '0;
            found_q <= 1'b0;
            dec_q <= 1'b0;
            just_q <= 1'b0;
            ln_q <= 3'd0;
            lv_q <= '0;
            pay_q <= '0;
            size_q <= request_size_i;
            addr_q <= address_i;
            cnt_nx_q <= count_q;
            heap_used_nx_q <= heap_used_q;
            status_q <= 1'b1;
            state_q <= ST_RSP;
            if (mode_i == MODE_ALLOC && ready_q) begin
              op_q <= OP_ALLOC;
              lag_q <= 2'd1;
              state_q <= ST_RUN;
            end else if (mode_i == MODE_FREE && ready_q) begin
              op_q <= OP_FREE;
              lag_q <= 2'd3;
              state_q <= ST_RUN;
            end else if (mode_i == MODE_INIT && initial_size_q <= cap &&
                         initial_size_q >= CfgBits'(HEADER_BYTES + 1)) begin
              op_q <= OP_INIT;
              lag_q <= 2'd1;
              found_q <= 1'b1;
              count_q <= CW'(1);
              cnt_nx_q <= CW'(1);
              heap_used_q <= initial_size_q;
              heap_used_nx_q <= initial_size_q;
              ready_q <= 1'b1;
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          t_q <= t_q + TW'(1);
          found_q <= found_d;
          dec_q <= dec_d;
          just_q <= just_d;
          pay_q <= pay_d;
          lq_q <= lq_d;
          lv_q <= lv_d;
          ln_q <= ln_d;
          cnt_nx_q <= cnt_nx_d;
          heap_used_nx_q <= heap_used_nx_d;
          if (last) begin
            count_q <= cnt_nx_d;
            heap_used_q <= heap_used_nx_d;
            status_q <= !found_d;
            if (!found_d || op_q != OP_ALLOC) begin
              pay_q <= '0;
            end
            state_q <= ST_RSP;
          end
        end
        ST_RSP: begin
          if (rsp_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o      = (state_q == ST_IDLE);
  assign rsp_valid_o      = (state_q == ST_RSP);
  assign status_o         = status_q;
  assign payload_offset_o = pay_q;

endmodule
`default_nettype wire

FILE: rtl/core/ffha_cell.sv
// One cell of the block table ring: holds one entry and passes it on.
`default_nettype none
module ffha_cell (
  input  wire                 clk_i,
  input  wire                 shift_i,
  input  wire ffha_pkg::ent_t ent_i,
  output ffha_pkg::ent_t      ent_o
);
  import ffha_pkg::*;

  ent_t ent_q;

  // Take the neighbor's entry on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= ent_i;
    end
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

FILE: dv/ffha_checker.sv
// Response checker for the first-fit heap allocator: predicts and compares.
module ffha_checker #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               req_valid_i,
  input  wire                               req_ready_i,
  input  wire  [1:0]                        mode_i,
  input  wire  [ffha_pkg::OffsetBits-1:0]   request_size_i,
  input  wire  [ffha_pkg::OffsetBits-1:0]   address_i,
  input  wire                               rsp_valid_i,
  input  wire                               rsp_ready_i,
  input  wire                               status_i,
  input  wire  [ffha_pkg::OffsetBits-1:0]   payload_offset_i,
  input  wire                               cfg_we_i,
  input  wire                               cfg_index_i,
  input  wire  [ffha_pkg::CfgBits-1:0]      cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                rsp_count_o,
  output int                                ok_alloc_o,
  output int                                ok_free_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  typedef struct packed {
    logic                  status;
    logic [OffsetBits-1:0] offset;
  } heap_rsp_t;

  // Shadow copy of the heap table and registers.
  logic [OffsetBits-1:0] blk_start [MAX_BLOCKS];
  logic [OffsetBits-1:0] blk_bytes [MAX_BLOCKS];
  logic                  blk_free  [MAX_BLOCKS];
  int unsigned           blk_count;
  longint unsigned       top_used;
  logic                  is_ready;
  logic [CfgBits-1:0]    limit_reg;
  logic [CfgBits-1:0]    init_reg;
  heap_rsp_t             rsp_queue[$];

  function automatic longint unsigned cap_limit();
    return (limit_reg < OffsetSpan) ? longint'(limit_reg) : longint'(OffsetSpan);
  endfunction

  function automatic void open_slot(int unsigned pos);
    for (int unsigned k = blk_count; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_bytes[k] = blk_bytes[k-1];
      blk_free[k]  = blk_free[k-1];
    end
    blk_count++;
  endfunction

  function automatic void drop_slot(int unsigned pos);
    for (int unsigned k = pos; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_bytes[k] = blk_bytes[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_count--;
  endfunction

  // Applies one request to the shadow heap and returns its response.
  function automatic heap_rsp_t heap_update(logic [1:0] mode, longint unsigned size,
                                            longint unsigned addr);
    heap_rsp_t r;
    longint unsigned left;
    int unsigned i;
    r.status = 1'b1;
    r.offset = '0;
    if (mode == MODE_INIT) begin
      if (init_reg <= cap_limit() && init_reg >= HEADER_BYTES + 1) begin
        blk_start[0] = '0;
        blk_bytes[0] = OffsetBits'(init_reg - HEADER_BYTES);
        blk_free[0]  = 1'b1;
        blk_count    = 1;
        top_used     = init_reg;
        is_ready     = 1'b1;
        r.status     = 1'b0;
      end
    end else if (mode == MODE_ALLOC && is_ready) begin
      for (i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_bytes[i] >= size) begin
          left = blk_bytes[i] - size;
          if (left >= HEADER_BYTES + 1 && blk_count < MAX_BLOCKS) begin
            open_slot(i + 1);
            blk_start[i+1] = OffsetBits'(blk_start[i] + HEADER_BYTES + size);
            blk_bytes[i+1] = OffsetBits'(left - HEADER_BYTES);
            blk_free[i+1]  = 1'b1;
            blk_bytes[i]   = OffsetBits'(size);
          end
          blk_free[i] = 1'b0;
          r.status = 1'b0;
          r.offset = OffsetBits'(blk_start[i] + HEADER_BYTES);
          return r;
        end
      end
      if (blk_count < MAX_BLOCKS && size + HEADER_BYTES + top_used < cap_limit()) begin
        i = blk_count;
        open_slot(i);
        blk_start[i] = OffsetBits'(top_used);
        blk_bytes[i] = OffsetBits'(size);
        blk_free[i]  = 1'b0;
        top_used     = top_used + HEADER_BYTES + size;
        r.status     = 1'b0;
        r.offset     = OffsetBits'(blk_start[i] + HEADER_BYTES);
      end
    end else if (mode == MODE_FREE && is_ready) begin
      for (i = 0; i < blk_count; i++) begin
        if (longint'(blk_start[i]) + HEADER_BYTES == addr) break;
      end
      if (i < blk_count && !blk_free[i]) begin
        blk_free[i] = 1'b1;
        if (i + 1 < blk_count && blk_free[i+1]) begin
          blk_bytes[i] = blk_bytes[i] + HEADER_BYTES + blk_bytes[i+1];
          drop_slot(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
          blk_bytes[i-1] = blk_bytes[i-1] + HEADER_BYTES + blk_bytes[i];
          drop_slot(i);
        end
        r.status = 1'b0;
      end
    end
    return r;
  endfunction

  // Track configuration, predict on each request, compare each response.
  always @(posedge clk_i or negedge rst_ni) begin
    heap_rsp_t want;
    if (!rst_ni) begin
      blk_count = 0;
      top_used  = 0;
      is_ready  = 1'b0;
      limit_reg = CfgBits'(1048576);
      init_reg  = CfgBits'(4096);
      rsp_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      rsp_count_o  <= 0;
      ok_alloc_o   <= 0;
      ok_free_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_HEAP_LIMIT) limit_reg = cfg_data_i;
        else init_reg = cfg_data_i;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        rsp_count_o <= rsp_count_o + 1;
        if (rsp_queue.size() == 0) begin
          $display("%0t: unexpected response status=%0b offset=%0h", $time,
                   status_i, payload_offset_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rsp_queue.pop_front();
          if (want.status !== status_i || want.offset !== payload_offset_i) begin
            $display("%0t: mismatch expected status=%0b offset=%0h actual status=%0b offset=%0h",
                     $time, want.status, want.offset, status_i, payload_offset_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = heap_update(mode_i, request_size_i, address_i);
        if (!want.status && mode_i == MODE_ALLOC) ok_alloc_o <= ok_alloc_o + 1;
        if (!want.status && mode_i == MODE_FREE) ok_free_o <= ok_free_o + 1;
        rsp_queue.push_back(want);
      end
      pending_o <= rsp_queue.size();
    end
  end
endmodule

FILE: dv/tb_first_fit_heap_allocator_unit.sv
// Testbench top for the first-fit heap allocator: stimulus and verdict.
module tb_first_fit_heap_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic [1:0]            mode = MODE_ALLOC;
  logic [OffsetBits-1:0] request_size = '0;
  logic [OffsetBits-1:0] address = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic                  status;
  logic [OffsetBits-1:0] payload_offset;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_HEAP_LIMIT;
  logic [CfgBits-1:0]    cfg_data = '0;
  int                    fail_count, pending, rsp_count, ok_alloc, ok_free;
  bit                    no_idle = 1'b0;
  int unsigned           quiet_cycles = 0;
  logic [OffsetBits-1:0] live_offsets[$];

  first_fit_heap_allocator_unit u_top (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready),
    .mode_i(mode), .request_size_i(request_size), .address_i(address),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready),
    .status_o(status), .payload_offset_o(payload_offset),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ffha_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_i(req_ready),
    .mode_i(mode), .request_size_i(request_size), .address_i(address),
    .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready),
    .status_i(status), .payload_offset_i(payload_offset),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .rsp_count_o(rsp_count),
    .ok_alloc_o(ok_alloc), .ok_free_o(ok_free)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Response side stalls at random unless a no-idle stretch is running.
  always @(posedge clk_i) begin
    rsp_ready <= no_idle || ($urandom_range(99) >= 29);
  end

  // Remember offsets handed out so frees can target live blocks.
  always @(posedge clk_i) begin
    if (rsp_valid && rsp_ready && !status && payload_offset != 0) begin
      live_offsets.push_back(payload_offset);
    end
  end

  // Watchdog on cycles without any accepted request, response or configuration write.
  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("[first_fit_heap_allocator_unit] ERROR");
      $finish;
    end
  end

  // Valid stays up from one request to the next unless an idle gap is drawn.
  task automatic send_request(logic [1:0] m, logic [OffsetBits-1:0] sz,
                              logic [OffsetBits-1:0] ad);
    while (!no_idle && $urandom_range(99) < 29) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid    <= 1'b1;
    mode         <= m;
    request_size <= sz;
    address      <= ad;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every response is back before touching the registers.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // Pick a free target: mostly a live block, sometimes a stray address.
  function automatic logic [OffsetBits-1:0] pick_address();
    int unsigned k;
    if (live_offsets.size() != 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(live_offsets.size() - 1);
      pick_address = live_offsets[k];
      live_offsets.delete(k);
    end else begin
      pick_address = ($urandom_range(1)) ? OffsetBits'($urandom)
                                         : OffsetBits'($urandom_range(4096));
    end
  endfunction

  function automatic logic [OffsetBits-1:0] pick_size();
    case ($urandom_range(9))
      0:       pick_size = '0;
      1:       pick_size = OffsetBits'($urandom);
      2, 3:    pick_size = OffsetBits'($urandom_range(2048));
      default: pick_size = OffsetBits'($urandom_range(200));
    endcase
  endfunction

  initial begin
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: uninitialized requests, unknown mode, extremes, bad init sizes.
    send_request(MODE_ALLOC, 20'd8, '0);
    send_request(MODE_FREE, '0, 20'd16);
    send_request(MODE_RSVD, '1, '1);
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, '0, '0);
    send_request(MODE_ALLOC, 20'd4000, '0);
    send_request(MODE_ALLOC, 20'd30, '0);
    send_request(MODE_ALLOC, '1, '0);
    send_request(MODE_FREE, '0, 20'd16);
    send_request(MODE_FREE, '0, 20'd16);
    send_request(MODE_FREE, '0, '1);
    send_request(MODE_FREE, '0, 20'd32);
    drain();
    write_reg(CFG_INITIAL_SIZE, CfgBits'(16));
    send_request(MODE_INIT, '0, '0);
    drain();
    write_reg(CFG_INITIAL_SIZE, CfgBits'(17));
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, 20'd1, '0);
    send_request(MODE_ALLOC, 20'd0, '0);
    drain();
    write_reg(CFG_HEAP_LIMIT, '1);
    write_reg(CFG_INITIAL_SIZE, CfgBits'(1048576));
    send_request(MODE_INIT, '0, '0);
    send_request(MODE_ALLOC, 20'd1048560, '0);
    send_request(MODE_FREE, '0, 20'd16);
    drain();
    write_reg(CFG_INITIAL_SIZE, '1);
    send_request(MODE_INIT, '0, '0);
    drain();
    live_offsets.delete();

    // Random phases over several register settings, each starting with an init.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph % 4)
        0: begin
          write_reg(CFG_HEAP_LIMIT, CfgBits'(1048576));
          write_reg(CFG_INITIAL_SIZE, CfgBits'(4096));
        end
        1: begin
          write_reg(CFG_HEAP_LIMIT, CfgBits'(3000));
          write_reg(CFG_INITIAL_SIZE, CfgBits'(17));
        end
        2: begin
          write_reg(CFG_HEAP_LIMIT, CfgBits'($urandom_range(1048576)));
          write_reg(CFG_INITIAL_SIZE, CfgBits'($urandom_range(20000)));
        end
        default: begin
          write_reg(CFG_HEAP_LIMIT, '0);
          write_reg(CFG_INITIAL_SIZE, '0);
        end
      endcase
      live_offsets.delete();
      no_idle = (ph == 5);
      send_request(MODE_INIT, '0, '0);
      for (int n = 0; n < 152; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) send_request(MODE_ALLOC, pick_size(), OffsetBits'($urandom));
        else if (pick < 93) send_request(MODE_FREE, OffsetBits'($urandom), pick_address());
        else if (pick < 96) send_request(MODE_INIT, OffsetBits'($urandom), OffsetBits'($urandom));
        else send_request(MODE_RSVD, OffsetBits'($urandom), OffsetBits'($urandom));
        if (pick >= 93 && pick < 96) live_offsets.delete();
      end
      no_idle = 1'b0;
    end

    // Let the last responses come back, with a bound.
    req_valid <= 1'b0;
    for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Run covered %0d responses: %0d allocations and %0d frees succeeded.",
             rsp_count, ok_alloc, ok_free);
    if (fail_count == 0 && pending == 0) begin
      $display("[first_fit_heap_allocator_unit] OK");
    end else begin
      $display("[first_fit_heap_allocator_unit] ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_cell.sv
rtl/core/first_fit_heap_allocator_unit.sv
dv/ffha_checker.sv
dv/tb_first_fit_heap_allocator_unit.sv
